/* hdl/sdcr_pkg.sv */
// Shared types and constants of the stereo dual-tap comb reverb.
package sdcr_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int GAIN_W      = 16;
    localparam int DELAY_W     = 11;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // words that may be outstanding between input and output
    localparam int OUT_CREDITS = 8;

    localparam int FIRST_DELAY_RESET     = 1376;
    localparam int SECOND_DELAY_RESET    = 1952;
    localparam int FIRST_FEEDBACK_RESET  = 27525;
    localparam int SECOND_FEEDBACK_RESET = 21627;
    localparam int WET_MIX_GAIN_RESET    = 36045;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [GAIN_W-1:0]          gain_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FIRST_DELAY     = 3'd0,
        REG_SECOND_DELAY    = 3'd1,
        REG_FIRST_FEEDBACK  = 3'd2,
        REG_SECOND_FEEDBACK = 3'd3,
        REG_WET_MIX_GAIN    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        sample_t dry_left;
        sample_t dry_right;
        sample_t send_left;
        sample_t send_right;
    } in_word_t;

    typedef struct packed {
        sample_t out_left;
        sample_t out_right;
    } out_word_t;

endpackage

/* hdl/stereo_dual_comb_reverb.sv */
// Stereo dual-tap feedback comb reverb: delay memories, datapath and output queue.
//
// Input channel: in_valid / in_stall / in_word (dry and send sample per side).
// Output channel: out_valid / out_stall / out_word (dry plus scaled echo per side).
// Config: cfg_write_en, cfg_index, cfg_data; write only while the block is idle.
//
// Path: tap reads, feedback products, wet gain and output mix, then the output queue.
// Throughput: one word per cycle unless in_stall holds the input. Both taps of each side
// are read in the accept cycle from a two-read, one-write memory per side; the echo is
// written back at the end of stage 2, and a read of that entry in the same cycle is bypassed.
// When a tap delay is one frame (modulo the depth) the echo of the word just
// accepted is still in the multiplier stage, so the next word is held until
// that echo reaches the write-back bypass.
// Reset: config takes its defaults, the write position and fill count clear.
// The delay memories are not swept; a tap that points at an entry not yet
// written since reset reads zero through the fill count.
// Receiver stall: results wait in an 8-word queue; in_stall rises once eight
// words are outstanding and falls as out_stall releases them.
module stereo_dual_comb_reverb
    import sdcr_pkg::*;
#(
    parameter int DELAY_DEPTH = 2048
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_word_t               in_word,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_word_t              out_word,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW     = $clog2(DELAY_DEPTH);
    localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
    localparam int SCL_W  = SAMPLE_W + 1;
    localparam int SUM_W  = SAMPLE_W + 3;
    localparam int QAW    = $clog2(OUT_CREDITS);
    localparam int CNT_W  = QAW + 1;

    localparam logic [AW-1:0] D1_RESET = AW'(FIRST_DELAY_RESET % DELAY_DEPTH);
    localparam logic [AW-1:0] D2_RESET = AW'(SECOND_DELAY_RESET % DELAY_DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(DELAY_DEPTH - 1);
    localparam logic [AW:0]   FULL_FILL = (AW+1)'(DELAY_DEPTH);
    localparam logic [CNT_W-1:0] CREDITS = CNT_W'(OUT_CREDITS);

    // delay modulo the depth, one conditional subtract per binary step
    function automatic logic [AW-1:0] reduce_delay(input logic [DELAY_W-1:0] d);
        logic [DELAY_W-1:0] r;
        r = d;
        for (int k = 4; k >= 0; k--) begin
            if (32'(r) >= (32'(DELAY_DEPTH) << k)) begin
                r = r - DELAY_W'(DELAY_DEPTH << k);
            end
        end
        return AW'(r);
    endfunction

    function automatic sample_t saturate(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-SAMPLE_W:0] top;
        top = v[SUM_W-1:SAMPLE_W-1];
        if (top == '0 || top == '1) begin
            return v[SAMPLE_W-1:0];
        end
        return v[SUM_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

    function automatic logic signed [SCL_W-1:0] scale_top(
        input logic signed [PROD_W-1:0] p);
        return signed'(p[PROD_W-1:GAIN_W]);
    endfunction

    function automatic logic [AW-1:0] tap_address(input logic [AW-1:0] pos,
                                                  input logic [AW-1:0] d);
        logic [AW:0] wrapped;
        wrapped = {1'b0, pos} + FULL_FILL - {1'b0, d};
        if (pos >= d) begin
            return pos - d;
        end
        return wrapped[AW-1:0];
    endfunction

    // configuration
    logic [AW-1:0] first_delay_reg;
    logic [AW-1:0] second_delay_reg;
    gain_t         first_feedback_reg;
    gain_t         second_feedback_reg;
    gain_t         wet_mix_gain_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            first_delay_reg     <= D1_RESET;
            second_delay_reg    <= D2_RESET;
            first_feedback_reg  <= gain_t'(FIRST_FEEDBACK_RESET);
            second_feedback_reg <= gain_t'(SECOND_FEEDBACK_RESET);
            wet_mix_gain_reg    <= gain_t'(WET_MIX_GAIN_RESET);
        end else if (cfg_write_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_FIRST_DELAY:     first_delay_reg     <= reduce_delay(cfg_data[DELAY_W-1:0]);
                REG_SECOND_DELAY:    second_delay_reg    <= reduce_delay(cfg_data[DELAY_W-1:0]);
                REG_FIRST_FEEDBACK:  first_feedback_reg  <= cfg_data[GAIN_W-1:0];
                REG_SECOND_FEEDBACK: second_feedback_reg <= cfg_data[GAIN_W-1:0];
                REG_WET_MIX_GAIN:    wet_mix_gain_reg    <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // write position, fill count, credits
    logic [AW-1:0]    pos_reg, pos_next;
    logic [AW:0]      fill_reg, fill_next;
    logic [CNT_W-1:0] pending_reg, pending_next;
    logic [AW-1:0]    tap1, tap2;
    logic             hazard;
    logic             accept;
    logic             deliver;

    logic             s1_valid_reg;
    logic [AW-1:0]    s1_pos_reg;

    assign tap1    = tap_address(pos_reg, first_delay_reg);
    assign tap2    = tap_address(pos_reg, second_delay_reg);
    // previous word's echo not yet written nor on the bypass
    assign hazard  = s1_valid_reg && (tap1 == s1_pos_reg || tap2 == s1_pos_reg);
    assign in_stall = (pending_reg == CREDITS) || hazard;
    assign accept  = in_valid && !in_stall;
    assign deliver = out_valid && !out_stall;

    always_comb begin
        pos_next     = pos_reg;
        fill_next    = fill_reg;
        pending_next = pending_reg;
        if (accept) begin
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
            if (fill_reg != FULL_FILL) begin
                fill_next = fill_reg + 1'b1;
            end
        end
        case ({accept, deliver})
            2'b10:   pending_next = pending_reg + 1'b1;
            2'b01:   pending_next = pending_reg - 1'b1;
            default: pending_next = pending_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg     <= '0;
            fill_reg    <= '0;
            pending_reg <= '0;
        end else begin
            pos_reg     <= pos_next;
            fill_reg    <= fill_next;
            pending_reg <= pending_next;
        end
    end

    // pipeline valids
    logic s2_valid_reg, s3_valid_reg, s4_valid_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: tap reads
    in_word_t s1_word_reg;
    logic     s1_ok1_reg, s1_ok2_reg;

    always_ff @(posedge clk) begin
        s1_word_reg <= in_word;
        s1_pos_reg  <= pos_reg;
        // entries at or beyond the fill count have not been written since reset
        s1_ok1_reg  <= ({1'b0, tap1} < fill_reg);
        s1_ok2_reg  <= ({1'b0, tap2} < fill_reg);
    end

    sample_t mem_left  [DELAY_DEPTH];
    sample_t mem_right [DELAY_DEPTH];
    sample_t rd_l1_reg, rd_l2_reg, rd_r1_reg, rd_r2_reg;

    logic [AW-1:0] s2_pos_reg;
    sample_t       echo_left, echo_right;
    logic          wr_hit1, wr_hit2;

    assign wr_hit1 = s2_valid_reg && (s2_pos_reg == tap1);
    assign wr_hit2 = s2_valid_reg && (s2_pos_reg == tap2);

    always_ff @(posedge clk) begin
        if (s2_valid_reg) begin
            mem_left[s2_pos_reg] <= echo_left;
        end
        rd_l1_reg <= wr_hit1 ? echo_left : mem_left[tap1];
        rd_l2_reg <= wr_hit2 ? echo_left : mem_left[tap2];
    end

    always_ff @(posedge clk) begin
        if (s2_valid_reg) begin
            mem_right[s2_pos_reg] <= echo_right;
        end
        rd_r1_reg <= wr_hit1 ? echo_right : mem_right[tap1];
        rd_r2_reg <= wr_hit2 ? echo_right : mem_right[tap2];
    end

    // stage 2: feedback products
    sample_t e_l1, e_l2, e_r1, e_r2;
    logic signed [PROD_W-1:0] p_l1_reg, p_l2_reg, p_r1_reg, p_r2_reg;
    sample_t s2_dry_l_reg, s2_dry_r_reg, s2_send_l_reg, s2_send_r_reg;

    assign e_l1 = s1_ok1_reg ? rd_l1_reg : '0;
    assign e_l2 = s1_ok2_reg ? rd_l2_reg : '0;
    assign e_r1 = s1_ok1_reg ? rd_r1_reg : '0;
    assign e_r2 = s1_ok2_reg ? rd_r2_reg : '0;

    always_ff @(posedge clk) begin
        p_l1_reg      <= signed'({1'b0, first_feedback_reg}) * e_l1;
        p_l2_reg      <= signed'({1'b0, second_feedback_reg}) * e_l2;
        p_r1_reg      <= signed'({1'b0, first_feedback_reg}) * e_r1;
        p_r2_reg      <= signed'({1'b0, second_feedback_reg}) * e_r2;
        s2_dry_l_reg  <= s1_word_reg.dry_left;
        s2_dry_r_reg  <= s1_word_reg.dry_right;
        s2_send_l_reg <= s1_word_reg.send_left;
        s2_send_r_reg <= s1_word_reg.send_right;
        s2_pos_reg    <= s1_pos_reg;
    end

    // echo sum, written back at the end of stage 2
    logic signed [SUM_W-1:0] echo_sum_l, echo_sum_r;

    assign echo_sum_l = SUM_W'(s2_send_l_reg) + SUM_W'(scale_top(p_l1_reg))
                      + SUM_W'(scale_top(p_l2_reg));
    assign echo_sum_r = SUM_W'(s2_send_r_reg) + SUM_W'(scale_top(p_r1_reg))
                      + SUM_W'(scale_top(p_r2_reg));
    assign echo_left  = saturate(echo_sum_l);
    assign echo_right = saturate(echo_sum_r);

    sample_t s3_echo_l_reg, s3_echo_r_reg, s3_dry_l_reg, s3_dry_r_reg;

    always_ff @(posedge clk) begin
        s3_echo_l_reg <= echo_left;
        s3_echo_r_reg <= echo_right;
        s3_dry_l_reg  <= s2_dry_l_reg;
        s3_dry_r_reg  <= s2_dry_r_reg;
    end

    // stage 3: wet gain
    logic signed [PROD_W-1:0] s4_prod_l_reg, s4_prod_r_reg;
    sample_t s4_dry_l_reg, s4_dry_r_reg;

    always_ff @(posedge clk) begin
        s4_prod_l_reg <= signed'({1'b0, wet_mix_gain_reg}) * s3_echo_l_reg;
        s4_prod_r_reg <= signed'({1'b0, wet_mix_gain_reg}) * s3_echo_r_reg;
        s4_dry_l_reg  <= s3_dry_l_reg;
        s4_dry_r_reg  <= s3_dry_r_reg;
    end

    // stage 4: output mix into the queue
    out_word_t result;

    assign result.out_left  = saturate(SUM_W'(s4_dry_l_reg) + SUM_W'(scale_top(s4_prod_l_reg)));
    assign result.out_right = saturate(SUM_W'(s4_dry_r_reg) + SUM_W'(scale_top(s4_prod_r_reg)));

    out_word_t        queue_mem [OUT_CREDITS];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] queue_count_reg, queue_count_next;

    always_ff @(posedge clk) begin
        if (s4_valid_reg) begin
            queue_mem[wr_ptr_reg] <= result;
        end
    end

    always_comb begin
        case ({s4_valid_reg, deliver})
            2'b10:   queue_count_next = queue_count_reg + 1'b1;
            2'b01:   queue_count_next = queue_count_reg - 1'b1;
            default: queue_count_next = queue_count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            queue_count_reg <= '0;
        end else begin
            if (s4_valid_reg) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (deliver) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            queue_count_reg <= queue_count_next;
        end
    end

    assign out_valid = (queue_count_reg != '0);
    assign out_word  = queue_mem[rd_ptr_reg];

endmodule

/* hdl/sdcr_checker.sv */
// Port-level checks of the comb reverb, bound to the top level.
module sdcr_checker
    import sdcr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_word
);

    logic [4:0] outstanding_reg, outstanding_next;
    logic       acc, dlv;

    assign acc = in_valid && !in_stall;
    assign dlv = out_valid && !out_stall;

    always_comb begin
        outstanding_next = outstanding_reg;
        if (acc && !dlv) begin
            outstanding_next = outstanding_reg + 1'b1;
        end else if (dlv && !acc) begin
            outstanding_next = outstanding_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            outstanding_reg <= '0;
        end else begin
            outstanding_reg <= outstanding_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == 5'd0 |-> !out_valid)
        else $error("output word with nothing outstanding");

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == 5'(OUT_CREDITS) |-> in_stall)
        else $error("input taken beyond the output queue's room");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        acc && outstanding_reg == 5'd0 |-> ##5 out_valid)
        else $error("result of an idle-block word late");

endmodule

bind stereo_dual_comb_reverb sdcr_checker u_sdcr_checker (.*);

/* sim/stereo_dual_comb_reverb_test.sv */
// Self-checking testbench of the stereo dual-tap comb reverb, with its own echo predictor.
module stereo_dual_comb_reverb_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sdcr_pkg::*;

    localparam int DEPTH         = 2048;
    localparam int LEFT          = 0;
    localparam int RIGHT         = 1;
    localparam int IDLE_PERCENT  = 11;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 80;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_WORDS   = 150;
    localparam int CALM_PHASE    = 3;
    localparam int LATE_HOLD     = 6;
    localparam int PRINT_LIMIT   = 100;

    localparam logic [CFG_INDEX_W-1:0] LAST_REG   = REG_WET_MIX_GAIN;
    localparam sample_t                SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t                SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    in_word_t               in_word      = '0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    out_word_t              out_word;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    // predictor copy of the registers and the delay memories
    logic [DELAY_W-1:0] tap1_delay = DELAY_W'(FIRST_DELAY_RESET);
    logic [DELAY_W-1:0] tap2_delay = DELAY_W'(SECOND_DELAY_RESET);
    gain_t              tap1_gain  = GAIN_W'(FIRST_FEEDBACK_RESET);
    gain_t              tap2_gain  = GAIN_W'(SECOND_FEEDBACK_RESET);
    gain_t              wet_gain   = GAIN_W'(WET_MIX_GAIN_RESET);
    sample_t            echo_mem [2][DEPTH];
    logic [DELAY_W-1:0] write_pos  = '0;

    in_word_t  pending_frames [$];
    out_word_t expected_outputs [$];

    logic in_fired = 1'b0;
    bit   calm     = 1'b0;
    int   mismatches, frames_accepted, outputs_checked, rail_hits, settings_used;
    int   hold_requests, holds_served, hold_left;

    stereo_dual_comb_reverb #(
        .DELAY_DEPTH(DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_word      (in_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_word     (out_word),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic sample_t clamp_sample(longint v);
        if (v > longint'(SAMPLE_MAX))
            return SAMPLE_MAX;
        if (v < longint'(SAMPLE_MIN))
            return SAMPLE_MIN;
        return sample_t'(v);
    endfunction

    // Q0.16 gain times sample, floor rounding
    function automatic longint scaled(gain_t g, sample_t s);
        return (longint'(g) * longint'(s)) >>> 16;
    endfunction

    function automatic out_word_t reverb_frame(in_word_t w);
        sample_t            dry [2];
        sample_t            send [2];
        sample_t            wet [2];
        sample_t            echo;
        logic [DELAY_W-1:0] tap1_pos;
        logic [DELAY_W-1:0] tap2_pos;
        out_word_t          r;
        dry[LEFT]   = w.dry_left;
        dry[RIGHT]  = w.dry_right;
        send[LEFT]  = w.send_left;
        send[RIGHT] = w.send_right;
        // address arithmetic wraps at the memory depth by width
        tap1_pos = write_pos - tap1_delay;
        tap2_pos = write_pos - tap2_delay;
        for (int s = 0; s < 2; s++)
        begin
            echo = clamp_sample(longint'(send[s]) + scaled(tap1_gain, echo_mem[s][tap1_pos])
                                + scaled(tap2_gain, echo_mem[s][tap2_pos]));
            echo_mem[s][write_pos] = echo;
            wet[s] = clamp_sample(longint'(dry[s]) + scaled(wet_gain, echo));
        end
        write_pos   = write_pos + 1'b1;
        r.out_left  = wet[LEFT];
        r.out_right = wet[RIGHT];
        return r;
    endfunction

    task automatic report_mismatch(string what, sample_t got, sample_t want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t ns mismatch: %s got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // predictor and checker, both on the rising edge
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n)
        begin
            in_fired <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                expected_outputs.push_back(reverb_frame(in_word));
                frames_accepted++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_outputs.size() == 0)
                    report_mismatch("output word with nothing outstanding", out_word.out_left, '0);
                else
                begin
                    want = expected_outputs.pop_front();
                    if (out_word.out_left !== want.out_left)
                        report_mismatch("out_left", out_word.out_left, want.out_left);
                    if (out_word.out_right !== want.out_right)
                        report_mismatch("out_right", out_word.out_right, want.out_right);
                    outputs_checked++;
                end
                if (out_word.out_left == SAMPLE_MAX || out_word.out_left == SAMPLE_MIN)
                    rail_hits++;
            end
        end
    end

    // sender: a word stays put until taken
    always @(negedge clk)
    begin
        if (!in_valid || in_fired)
        begin
            if (pending_frames.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT))
            begin
                in_word  <= pending_frames.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls plus the occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_left == 0 && hold_requests != holds_served)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && $urandom_range(99) < IDLE_PERCENT;
    end

    task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        case (idx)
            REG_FIRST_DELAY:     tap1_delay = val[DELAY_W-1:0];
            REG_SECOND_DELAY:    tap2_delay = val[DELAY_W-1:0];
            REG_FIRST_FEEDBACK:  tap1_gain  = val;
            REG_SECOND_FEEDBACK: tap2_gain  = val;
            REG_WET_MIX_GAIN:    wet_gain   = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic send_frame(sample_t dl, sample_t dr, sample_t sl, sample_t sr);
        in_word_t f;
        f.dry_left   = dl;
        f.dry_right  = dr;
        f.send_left  = sl;
        f.send_right = sr;
        pending_frames.push_back(f);
    endtask

    // settle after the NBAs of the falling edge, then look
    task automatic wait_idle();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (pending_frames.size() != 0 || in_valid || expected_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return sample_t'($urandom_range(511)) - sample_t'(256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // mostly short taps so the feedback builds up inside a phase
    function automatic logic [CFG_DATA_W-1:0] pick_delay();
        case ($urandom_range(9))
            0: return '0;
            1: return 16'd1;
            2: return 16'd2;
            3: return 16'd2047;
            4: return CFG_DATA_W'($urandom_range(65535));
            5, 6, 7: return CFG_DATA_W'($urandom_range(40, 2));
            default: return CFG_DATA_W'($urandom_range(2047, 2));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(5))
            0: return '0;
            1: return 16'hFFFF;
            2: return CFG_DATA_W'($urandom_range(49152, 16384));
            default: return CFG_DATA_W'($urandom_range(65535));
        endcase
    endfunction

    task automatic random_setting();
        set_reg(REG_FIRST_DELAY, pick_delay());
        set_reg(REG_SECOND_DELAY, pick_delay());
        set_reg(REG_FIRST_FEEDBACK, pick_gain());
        set_reg(REG_SECOND_FEEDBACK, pick_gain());
        if ($urandom_range(2) == 0)
            set_reg(CFG_INDEX_W'(LAST_REG + 1 + $urandom_range(2)), CFG_DATA_W'($urandom));
        set_reg(REG_WET_MIX_GAIN, pick_gain());
        settings_used++;
    endtask

    initial
    begin
        for (int s = 0; s < 2; s++)
            for (int a = 0; a < DEPTH; a++)
                echo_mem[s][a] = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: field extremes and bit patterns
        send_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        send_frame(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        send_frame('0, '0, '0, '0);
        send_frame(-1, -1, -1, -1);
        send_frame(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA);
        send_frame(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555);
        wait_idle();
        settings_used++;

        // one- and two-frame taps at full gain: echo and output both clip
        set_reg(REG_FIRST_DELAY, 16'd1);
        set_reg(REG_SECOND_DELAY, 16'd2);
        set_reg(REG_FIRST_FEEDBACK, 16'hFFFF);
        set_reg(REG_SECOND_FEEDBACK, 16'hFFFF);
        set_reg(REG_WET_MIX_GAIN, 16'hFFFF);
        settings_used++;
        repeat (5) send_frame(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
        repeat (5) send_frame(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        repeat (2) send_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN);
        wait_idle();

        // oversized delay keeps its low bits (zero tap), longest tap, spare indexes ignored
        set_reg(REG_FIRST_DELAY, 16'hF800);
        set_reg(REG_SECOND_DELAY, 16'd2047);
        set_reg(REG_FIRST_FEEDBACK, '0);
        set_reg(REG_SECOND_FEEDBACK, 16'hFFFF);
        set_reg(REG_WET_MIX_GAIN, '0);
        for (int k = 1; k <= 3; k++)
            set_reg(CFG_INDEX_W'(LAST_REG + k), 16'hFFFF);
        settings_used++;
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 24'h123456, -24'sd77);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, -24'sd1, 24'sd1);
        send_frame(24'sd1000, -24'sd1000, SAMPLE_MAX, SAMPLE_MIN);
        send_frame('0, '0, '0, '0);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            // last phase: zero tap reads entries not yet written, one-frame tap interlocks
            if (p == RANDOM_PHASES - 1)
            begin
                set_reg(REG_FIRST_DELAY, '0);
                set_reg(REG_SECOND_DELAY, 16'd1);
                set_reg(REG_FIRST_FEEDBACK, pick_gain());
                set_reg(REG_SECOND_FEEDBACK, pick_gain());
                set_reg(REG_WET_MIX_GAIN, pick_gain());
                settings_used++;
            end
            else
                random_setting();
            calm = (p == CALM_PHASE);
            for (int n = 0; n < PHASE_WORDS; n++)
                send_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample());
            // long receiver hold while the sender keeps offering
            if (p == CALM_PHASE || p == LATE_HOLD)
                hold_requests++;
            wait_idle();
        end
        calm = 1'b0;

        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Run covered %0d stereo frames under %0d register settings, %0d results checked.",
                 frames_accepted, settings_used, outputs_checked);
        $display("Taps from 0 to 2047 frames, %0d left outputs clipped,", rail_hits);
        $display("  %0d long receiver hold-offs.", holds_served);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

endmodule
